@@ sv/rlcs_pkg.sv @@
package rlcs_pkg;

    // Default sizes of the point table and of a column
    localparam int MAX_POINTS_DEF  = 64;
    localparam int COLUMN_BITS_DEF = 16;

    // Fixed payload widths
    localparam int COLOR_W  = 16;
    localparam int OP_W     = 1;
    localparam int STATUS_W = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_QUERY = 1'b0;
    localparam logic [OP_W-1:0] OP_PAINT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // latch a new item and clear the walk
        logic read;    // fetch the entry at the walk index
        logic eval;    // handle the fetched entry
        logic tail;    // insert what the walk still owes after the last entry
        logic commit;  // publish the result and, for a paint that fits, swap in the new list
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic more;       // entries remain to be walked
        logic advance;    // the fetched entry is finished
        logic tail_done;  // no insertion left
        logic out_free;   // result register can take a new result
    } t_stat;

endpackage

@@ sv/rlcs_if.sv @@
interface rlcs_in_if #(
    parameter int COL_W = rlcs_pkg::COLUMN_BITS_DEF
);
    import rlcs_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [COL_W-1:0]   column;
    logic [COL_W-1:0]   span_length;
    logic [COLOR_W-1:0] paint_color;

    modport source (output valid, output operation, output column, output span_length,
                    output paint_color, input ready);
    modport sink (input valid, input operation, input column, input span_length,
                  input paint_color, output ready);
endinterface

interface rlcs_out_if #(
    parameter int CNT_W = $clog2(rlcs_pkg::MAX_POINTS_DEF + 1)
);
    import rlcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [COLOR_W-1:0]  color_at_column;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    change_count_now;

    modport source (output valid, output color_at_column, output status,
                    output change_count_now, input ready);
    modport sink (input valid, input color_at_column, input status,
                  input change_count_now, output ready);
endinterface

@@ sv/run_length_color_span_table.sv @@
// Channel  Role    Fields
// i_req    sink    operation, column, span_length, paint_color
// o_rsp    source  color_at_column, status, change_count_now
//
// One item at a time: a paint costs more than a query, since its start and
// restore checks each take a walk step of their own, whether or not a point is
// inserted. The item time is set by the walk over the point memory: one read
// port, and each entry is fetched, then handled. Reset empties the table at
// once; no clearing pass.
// A result waits in an output register; the next item is taken meanwhile, and
// a stalled o_rsp holds only the commit of that next item.
module run_length_color_span_table #(
    parameter int MAX_POINTS  = rlcs_pkg::MAX_POINTS_DEF,
    parameter int COLUMN_BITS = rlcs_pkg::COLUMN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlcs_in_if.sink    i_req,
    rlcs_out_if.source o_rsp
);
    import rlcs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rlcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rlcs_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

@@ sv/rlcs_ctrl.sv @@
module rlcs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rlcs_pkg::t_stat i_stat,
    output rlcs_pkg::t_cmd  o_cmd
);
    import rlcs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_TAIL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and sequence the walk
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (i_stat.more) begin
                    o_cmd.read = 1'b1;
                    n_state    = S_EVAL;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.advance) begin
                    n_state = S_READ;
                end
            end
            S_TAIL: begin
                o_cmd.tail = 1'b1;
                if (i_stat.tail_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/rlcs_dp.sv @@
module rlcs_dp #(
    parameter int MAX_POINTS  = rlcs_pkg::MAX_POINTS_DEF,
    parameter int COLUMN_BITS = rlcs_pkg::COLUMN_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rlcs_in_if.sink         i_req,
    rlcs_out_if.source      o_rsp,
    input  rlcs_pkg::t_cmd  i_cmd,
    output rlcs_pkg::t_stat o_stat
);
    import rlcs_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int N_W   = $clog2(MAX_POINTS + 3);
    localparam logic [N_W-1:0]         MAX_N   = N_W'(MAX_POINTS);
    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_BEFORE = 3'b001,
        PH_INSIDE = 3'b010,
        PH_AFTER  = 3'b100
    } t_phase;

    // Two banks: the live list and the one being rebuilt
    logic [COLUMN_BITS-1:0] mem_col   [2][MAX_POINTS];
    logic [COLOR_W-1:0]     mem_color [2][MAX_POINTS];

    logic [OP_W-1:0]        r_op,     n_op;
    logic [COLUMN_BITS-1:0] r_s,      n_s;
    logic [COLUMN_BITS-1:0] r_e,      n_e;
    logic [COLUMN_BITS:0]   r_q,      n_q;
    logic [COLOR_W-1:0]     r_color,  n_color;
    logic [COLOR_W-1:0]     r_oldcol, n_oldcol;
    logic [COLOR_W-1:0]     r_result, n_result;
    t_phase                 r_phase,  n_phase;
    logic [CNT_W-1:0]       r_idx,    n_idx;
    logic [N_W-1:0]         r_n,      n_n;
    logic [CNT_W-1:0]       r_count,  n_count;
    logic                   r_bank,   n_bank;
    logic [COLUMN_BITS-1:0] r_rd_col;
    logic [COLOR_W-1:0]     r_rd_color;

    logic                   r_out_valid;
    logic [COLOR_W-1:0]     r_out_color;
    logic [STATUS_W-1:0]    r_out_status;
    logic [CNT_W-1:0]       r_out_count;

    logic                   wr_en;
    logic [COLUMN_BITS-1:0] wr_col;
    logic [COLOR_W-1:0]     wr_color;
    logic                   paint_ok;
    logic [COLUMN_BITS:0]   s_sum;
    logic [COLUMN_BITS-1:0] s_sat;
    logic [COLUMN_BITS:0]   e_sum;

    // Saturate the one-based range start and end
    always_comb begin
        s_sum = {1'b0, i_req.column} + {{COLUMN_BITS{1'b0}}, 1'b1};
        s_sat = s_sum[COLUMN_BITS] ? COL_MAX : s_sum[COLUMN_BITS-1:0];
        e_sum = {1'b0, s_sat} + {1'b0, i_req.span_length};
    end

    assign paint_ok = (r_n <= MAX_N);

    // Walk step: keep, insert or drop one point
    always_comb begin
        n_op     = r_op;
        n_s      = r_s;
        n_e      = r_e;
        n_q      = r_q;
        n_color  = r_color;
        n_oldcol = r_oldcol;
        n_result = r_result;
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_n      = r_n;
        n_count  = r_count;
        n_bank   = r_bank;
        wr_en    = 1'b0;
        wr_col   = r_rd_col;
        wr_color = r_rd_color;
        o_stat.more      = (r_idx < r_count);
        o_stat.out_free  = !r_out_valid || o_rsp.ready;
        o_stat.advance   = 1'b0;
        o_stat.tail_done = 1'b0;

        if (i_cmd.load) begin
            n_op     = i_req.operation;
            n_s      = s_sat;
            n_e      = e_sum[COLUMN_BITS] ? COL_MAX : e_sum[COLUMN_BITS-1:0];
            n_q      = s_sum;
            n_color  = i_req.paint_color;
            n_oldcol = '0;
            n_result = '0;
            n_phase  = PH_BEFORE;
            n_idx    = '0;
            n_n      = '0;
        end

        if (i_cmd.eval) begin
            if (r_op == OP_QUERY) begin
                if ({1'b0, r_rd_col} <= r_q) begin
                    n_result = r_rd_color;
                end
                o_stat.advance = 1'b1;
            end else begin
                case (r_phase)
                    PH_BEFORE: begin
                        if (r_rd_col < r_s) begin
                            wr_en          = 1'b1;
                            n_oldcol       = r_rd_color;
                            o_stat.advance = 1'b1;
                        end else begin
                            wr_en    = (r_color != r_oldcol);
                            wr_col   = r_s;
                            wr_color = r_color;
                            n_phase  = PH_INSIDE;
                        end
                    end
                    PH_INSIDE: begin
                        if (r_rd_col <= r_e) begin
                            n_oldcol       = r_rd_color;
                            o_stat.advance = 1'b1;
                        end else begin
                            wr_en    = (r_color != r_oldcol);
                            wr_col   = r_e;
                            wr_color = r_oldcol;
                            n_phase  = PH_AFTER;
                        end
                    end
                    default: begin
                        wr_en          = 1'b1;
                        o_stat.advance = 1'b1;
                    end
                endcase
            end
            if (o_stat.advance) begin
                n_idx = r_idx + CNT_W'(1);
            end
        end

        // Add the start or restore point still owed at the end of the list
        if (i_cmd.tail) begin
            if (r_op == OP_QUERY) begin
                o_stat.tail_done = 1'b1;
            end else begin
                case (r_phase)
                    PH_BEFORE: begin
                        wr_en    = (r_color != r_oldcol);
                        wr_col   = r_s;
                        wr_color = r_color;
                        n_phase  = PH_INSIDE;
                    end
                    PH_INSIDE: begin
                        wr_en    = (r_color != r_oldcol);
                        wr_col   = r_e;
                        wr_color = r_oldcol;
                        n_phase  = PH_AFTER;
                    end
                    default: begin
                        o_stat.tail_done = 1'b1;
                    end
                endcase
            end
        end

        if (wr_en) begin
            n_n = r_n + N_W'(1);
        end

        // Swap in the rebuilt list unless it overflowed
        if (i_cmd.commit && (r_op == OP_PAINT) && paint_ok) begin
            n_bank  = ~r_bank;
            n_count = r_n[CNT_W-1:0];
        end
    end

    // Point storage: write the rebuilt bank, read the live bank
    always_ff @(posedge i_clk) begin
        if (wr_en && (r_n < MAX_N)) begin
            mem_col[~r_bank][r_n[IDX_W-1:0]]   <= wr_col;
            mem_color[~r_bank][r_n[IDX_W-1:0]] <= wr_color;
        end
        if (i_cmd.read) begin
            r_rd_col   <= mem_col[r_bank][r_idx[IDX_W-1:0]];
            r_rd_color <= mem_color[r_bank][r_idx[IDX_W-1:0]];
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_s      <= n_s;
        r_e      <= n_e;
        r_q      <= n_q;
        r_color  <= n_color;
        r_oldcol <= n_oldcol;
        r_result <= n_result;
        r_phase  <= n_phase;
        r_idx    <= n_idx;
        r_n      <= n_n;
    end

    // Table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_bank  <= n_bank;
        end
    end

    // Result register: load on commit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_color  <= (r_op == OP_QUERY) ? r_result : '0;
            r_out_status <= ((r_op == OP_PAINT) && !paint_ok) ? STATUS_FULL : STATUS_OK;
            r_out_count  <= n_count;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.color_at_column  = r_out_color;
    assign o_rsp.status           = r_out_status;
    assign o_rsp.change_count_now = r_out_count;

endmodule

@@ sv/rlcs_checker.sv @@
module rlcs_checker #(
    parameter int MAX_POINTS = rlcs_pkg::MAX_POINTS_DEF,
    parameter int CNT_W      = $clog2(rlcs_pkg::MAX_POINTS_DEF + 1)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [rlcs_pkg::COLOR_W-1:0]  i_out_color,
    input logic [rlcs_pkg::STATUS_W-1:0] i_out_status,
    input logic [CNT_W-1:0]              i_out_count
);
    import rlcs_pkg::*;

    logic [CNT_W-1:0] r_last_count;

    // Track the point count of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_count <= i_out_count;
        end
    end

    // One item at a time: no transfer right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while an item is in flight");

    // A rejected paint leaves the table as it was
    a_reject_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status == STATUS_FULL)) |->
        ((i_out_count == r_last_count) && (i_out_color == '0)))
        else $error("rejected paint changed the table");

    // The count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count <= CNT_W'(MAX_POINTS)))
        else $error("point count beyond table size");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_count) && $stable(i_out_color)))
        else $error("stalled result changed");

endmodule

bind run_length_color_span_table rlcs_checker #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      ($clog2(MAX_POINTS + 1))
) u_rlcs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_color  (o_rsp.color_at_column),
    .i_out_status (o_rsp.status),
    .i_out_count  (o_rsp.change_count_now)
);

@@ bench/testbench.sv @@
module testbench;
    import rlcs_pkg::*;

    localparam int MAX_PTS     = MAX_POINTS_DEF;
    localparam int COL_W       = COLUMN_BITS_DEF;
    localparam int CNT_W       = $clog2(MAX_PTS + 1);
    localparam int MAX_COL     = (1 << COL_W) - 1;
    localparam int ITEM_CYCLES = 2 * MAX_PTS + 5;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_ROWS    = 23;

    typedef struct packed {
        logic [COLOR_W-1:0]  color;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
    } span_result_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COL_W-1:0]   column;
        logic [COL_W-1:0]   span;
        logic [COLOR_W-1:0] color;
        bit                 typed;
        span_result_t       want;
    } span_row_t;

    logic i_clk;
    logic i_rst_n;

    rlcs_in_if  #(.COL_W(COL_W)) req_if ();
    rlcs_out_if #(.CNT_W(CNT_W)) rsp_if ();

    run_length_color_span_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the color-change list
    logic [COL_W-1:0]   point_col [MAX_PTS];
    logic [COLOR_W-1:0] point_clr [MAX_PTS];
    int unsigned        point_num = 0;

    span_result_t pending_results [$];

    int unsigned idle_odds       = 0;
    bit          hold_off_req    = 1'b0;
    int unsigned mismatches      = 0;
    int unsigned results_checked = 0;
    int unsigned queries_sent    = 0;
    int unsigned paints_sent     = 0;
    int unsigned paints_refused  = 0;

    // Directed items: extremes, zero length, saturation, full clears
    span_row_t directed_rows [NUM_ROWS] = '{
        '{OP_QUERY, 0,       0,       0,       1, '{0, STATUS_OK, 0}},
        '{OP_QUERY, 65534,   16'hFFFF, 16'hFFFF, 1, '{0, STATUS_OK, 0}},
        '{OP_PAINT, 0,       0,       5,       1, '{0, STATUS_OK, 2}},
        '{OP_QUERY, 0,       0,       0,       0, '0},
        '{OP_PAINT, 65534,   65535,   16'hFFFF, 1, '{0, STATUS_OK, 4}},
        '{OP_QUERY, 65534,   0,       0,       0, '0},
        '{OP_QUERY, 65533,   0,       0,       0, '0},
        '{OP_PAINT, 0,       65535,   0,       1, '{0, STATUS_OK, 0}},
        '{OP_PAINT, 9,       10,      3,       1, '{0, STATUS_OK, 2}},
        '{OP_QUERY, 8,       0,       0,       0, '0},
        '{OP_QUERY, 9,       0,       0,       0, '0},
        '{OP_QUERY, 18,      0,       0,       0, '0},
        '{OP_QUERY, 19,      0,       0,       0, '0},
        '{OP_PAINT, 14,      10,      3,       0, '0},
        '{OP_PAINT, 4,       2,       7,       0, '0},
        '{OP_PAINT, 100,     0,       0,       0, '0},
        '{OP_PAINT, 16'h5555, 16'hAAAA, 16'hAAAA, 0, '0},
        '{OP_PAINT, 16'h2AAA, 16'h5555, 16'h5555, 0, '0},
        '{OP_QUERY, 16'h7FFF, 0,      0,       0, '0},
        '{OP_QUERY, 16'h5554, 0,      0,       0, '0},
        '{OP_PAINT, 0,       65535,   16'hFFFF, 0, '0},
        '{OP_QUERY, 32767,   0,       0,       0, '0},
        '{OP_PAINT, 0,       65535,   0,       1, '{0, STATUS_OK, 0}}
    };

    // Color of the last point at or before a one-based column
    function automatic logic [COLOR_W-1:0] color_in_force(int unsigned pos);
        logic [COLOR_W-1:0] c;
        c = '0;
        for (int unsigned i = 0; i < point_num; i++) begin
            if (point_col[i] > pos) break;
            c = point_clr[i];
        end
        return c;
    endfunction

    // Rebuild the list for a painted range; leave it alone on overflow
    function automatic bit paint_span(logic [COL_W-1:0] column, logic [COL_W-1:0] span,
                                      logic [COLOR_W-1:0] color);
        logic [COL_W-1:0]   new_col [MAX_PTS+2];
        logic [COLOR_W-1:0] new_clr [MAX_PTS+2];
        logic [COLOR_W-1:0] prior;
        int unsigned        first, last, n, i;
        prior = '0;
        n     = 0;
        i     = 0;
        first = 32'(column) + 1;
        if (first > MAX_COL) first = MAX_COL;
        last = first + 32'(span);
        if (last > MAX_COL) last = MAX_COL;
        // keep points ahead of the range
        while (i < point_num && point_col[i] < first) begin
            prior      = point_clr[i];
            new_col[n] = point_col[i];
            new_clr[n] = point_clr[i];
            n++;
            i++;
        end
        if (color != prior) begin
            new_col[n] = COL_W'(first);
            new_clr[n] = color;
            n++;
        end
        // drop points covered by the range
        while (i < point_num && point_col[i] <= last) begin
            prior = point_clr[i];
            i++;
        end
        if (color != prior) begin
            new_col[n] = COL_W'(last);
            new_clr[n] = prior;
            n++;
        end
        // keep points after the range
        while (i < point_num) begin
            if (n >= MAX_PTS + 2) return 1'b0;
            new_col[n] = point_col[i];
            new_clr[n] = point_clr[i];
            n++;
            i++;
        end
        if (n > MAX_PTS) return 1'b0;
        for (int unsigned k = 0; k < n; k++) begin
            point_col[k] = new_col[k];
            point_clr[k] = new_clr[k];
        end
        point_num = n;
        return 1'b1;
    endfunction

    function automatic span_result_t predict_span_result(logic [OP_W-1:0] op,
                                                         logic [COL_W-1:0] column,
                                                         logic [COL_W-1:0] span,
                                                         logic [COLOR_W-1:0] color);
        span_result_t r;
        r        = '0;
        r.status = STATUS_OK;
        if (op == OP_QUERY) begin
            r.color = color_in_force(32'(column) + 1);
        end else if (!paint_span(column, span, color)) begin
            r.status = STATUS_FULL;
        end
        r.count = CNT_W'(point_num);
        return r;
    endfunction

    // Offer one item, wait for the transfer, then record what must come back
    task automatic issue_span_op(logic [OP_W-1:0] op, logic [COL_W-1:0] column,
                                 logic [COL_W-1:0] span, logic [COLOR_W-1:0] color,
                                 bit typed, span_result_t want);
        span_result_t predicted;
        if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.column      <= column;
        req_if.span_length <= span;
        req_if.paint_color <= color;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = predict_span_result(op, column, span, color);
        pending_results.push_back(typed ? want : predicted);
        if (op == OP_QUERY) begin
            queries_sent++;
        end else begin
            paints_sent++;
            if (predicted.status == STATUS_FULL) paints_refused++;
        end
    endtask

    // Mostly near the start of the line, where paints overlap
    function automatic logic [COL_W-1:0] pick_column();
        if ($urandom_range(99) < 85) return COL_W'($urandom_range(511));
        return COL_W'($urandom_range(MAX_COL - 1));
    endfunction

    // A small palette makes same-color merges common
    function automatic logic [COLOR_W-1:0] pick_color();
        if ($urandom_range(9) < 7) return COLOR_W'($urandom_range(3));
        return COLOR_W'($urandom);
    endfunction

    function automatic logic [COL_W-1:0] pick_span();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 88) return COL_W'($urandom_range(40, 1));
        return COL_W'($urandom);
    endfunction

    task automatic run_mixed(int unsigned count, bit calm);
        for (int unsigned k = 0; k < count; k++) begin
            if (calm) begin
                idle_odds = 0;
            end else if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0: idle_odds = 0;
                    1: idle_odds = 4;
                    default: idle_odds = 12;
                endcase
            end
            if ($urandom_range(9) < 4) begin
                issue_span_op(OP_QUERY, pick_column(), COL_W'($urandom),
                              COLOR_W'($urandom), 1'b0, '0);
            end else begin
                issue_span_op(OP_PAINT, pick_column(), pick_span(), pick_color(), 1'b0, '0);
            end
        end
    endtask

    // Clear the line, then lay disjoint spans until the list overflows
    task automatic fill_to_overflow();
        logic [COL_W-1:0] base;
        issue_span_op(OP_PAINT, '0, COL_W'(MAX_COL), '0, 1'b0, '0);
        for (int unsigned k = 0; k < MAX_PTS / 2 + 6; k++) begin
            base = COL_W'(k * 16);
            issue_span_op(OP_PAINT, base + COL_W'($urandom_range(3)),
                          COL_W'($urandom_range(6, 1)),
                          COLOR_W'($urandom_range(65535, 1)), 1'b0, '0);
            if ($urandom_range(3) == 0) begin
                issue_span_op(OP_QUERY, COL_W'($urandom_range(k * 16 + 8)), '0, '0,
                              1'b0, '0);
            end
        end
        // zero-length paint on a full list
        issue_span_op(OP_PAINT, COL_W'(3), '0, COLOR_W'(16'h1234), 1'b0, '0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned stall;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_if.ready <= 1'b0;
                for (stall = 0; stall < HOLD_CYCLES; stall++) @(posedge i_clk);
            end else if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(15, 1)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        span_result_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got color %h status %h count %0d",
                         $time, rsp_if.color_at_column, rsp_if.status,
                         rsp_if.change_count_now);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (rsp_if.color_at_column !== want.color) begin
                    $display("%0t: color_at_column expected %h, got %h",
                             $time, want.color, rsp_if.color_at_column);
                    mismatches++;
                end
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status expected %h, got %h",
                             $time, want.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.change_count_now !== want.count) begin
                    $display("%0t: change_count_now expected %0d, got %0d",
                             $time, want.count, rsp_if.change_count_now);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_QUERY;
        req_if.column      <= '0;
        req_if.span_length <= '0;
        req_if.paint_color <= '0;
        i_rst_n            <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            issue_span_op(directed_rows[r].op, directed_rows[r].column, directed_rows[r].span,
                          directed_rows[r].color, directed_rows[r].typed,
                          directed_rows[r].want);
        end

        run_mixed(230, 1'b0);
        fill_to_overflow();
        run_mixed(40, 1'b0);
        // stall the result side while items keep coming
        hold_off_req = 1'b1;
        run_mixed(230, 1'b0);
        run_mixed(80, 1'b1);

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (ITEM_CYCLES + 20) @(posedge i_clk);

        $display("Sent %0d queries and %0d paints, %0d paints refused on a full list.",
                 queries_sent, paints_sent, paints_refused);
        $display("Compared %0d results field by field, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ run_length_color_span_table.f @@
sv/rlcs_pkg.sv
sv/rlcs_if.sv
sv/rlcs_ctrl.sv
sv/rlcs_dp.sv
sv/run_length_color_span_table.sv
sv/rlcs_checker.sv
bench/testbench.sv
